FILE: rtl/mfta_pkg.sv
// Package with shared constants and types for the MAC forwarding table.
`default_nettype none
package mfta_pkg;
  localparam int TableDepth = 4096;
  localparam int KeepAfterTrim = 256;
  localparam int AddrW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int MacW = 48;
  localparam int IdW = 8;
  localparam int EntW = MacW + IdW + 1;

  localparam logic [2:0] ModeLookup = 3'd0;
  localparam logic [2:0] ModeLearn = 3'd1;
  localparam logic [2:0] ModeDelMac = 3'd2;
  localparam logic [2:0] ModeDelId = 3'd3;
  localparam logic [2:0] ModeTick = 3'd4;

  localparam logic [1:0] CfgFlood = 2'd0;
  localparam logic [1:0] CfgIdMin = 2'd1;
  localparam logic [1:0] CfgIdMax = 2'd2;

  typedef struct packed {
    logic [MacW-1:0] mac;
    logic [IdW-1:0]  id;
    logic            fresh;
  } entry_t;
endpackage
`default_nettype wire

FILE: rtl/mfta_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module mfta_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

FILE: rtl/mac_forwarding_table_aging.sv
// A lookup or an update of a present address costs one binary search, each probe taking
// S_SRCH to address the RAM and S_SRCHW to compare, then S_DECIDE.
// Inserts, removals, purges and aging ticks walk the table entry by entry through the
// single RAM port; a learn into a full table first ages it.
// One request at a time: in_ready is low from acceptance until the result is registered.
// Reset (synchronous, rst_n low) clears the count, state and out_valid and loads the
// config defaults; entries at or above the count go unused, so no clearing is needed.
`default_nettype none
module mac_forwarding_table_aging
  import mfta_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_mode,
  input  wire logic [47:0] in_mac,
  input  wire logic [7:0]  in_station_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic [7:0]       out_dest_id,
  output logic [12:0]      out_entry_count,
  output logic             out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCHW, S_DECIDE, S_WALKRD, S_WALKW, S_SHIFTRD, S_SHIFTW,
    S_INSW, S_AGEEND, S_CLRRD, S_CLRW, S_DONE
  } state_t;

  // Walk kinds used by the compaction pass.
  typedef enum logic [1:0] {W_DEL, W_ID, W_STALE} walk_t;

  state_t state_r;
  walk_t walk_r;
  logic [2:0] mode_r;
  logic [MacW-1:0] mac_r;
  logic [IdW-1:0] sid_r;
  logic [7:0] flood_r, idmin_r, idmax_r;
  logic [CntW-1:0] count_r, lo_r, hi_r, rd_r, wr_r;
  logic hit_r, after_age_r;
  logic [IdW-1:0] dest_r;
  logic status_r;
  logic ins_pending_r;

  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  entry_t ram_wdata, ram_rdata;
  logic [EntW-1:0] ram_q;

  mfta_ram #(.Width(EntW), .Depth(TableDepth)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_q)
  );
  assign ram_rdata = entry_t'(ram_q);

  logic [CntW-1:0] mid;
  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  logic id_ok;
  assign id_ok = (sid_r >= idmin_r) && (sid_r <= idmax_r);

  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Address and write data for the single RAM port.
  always_comb begin
    ram_we = 1'b0;
    ram_addr = rd_r[AddrW-1:0];
    ram_wdata = ram_rdata;
    unique case (state_r)
      S_SRCH: ram_addr = mid[AddrW-1:0];
      S_WALKW: begin
        ram_addr = wr_r[AddrW-1:0];
        unique case (walk_r)
          W_DEL: ram_we = 1'b1;
          W_ID: ram_we = (ram_rdata.id != sid_r);
          default: ram_we = ram_rdata.fresh;
        endcase
      end
      S_SHIFTW: begin
        ram_addr = wr_r[AddrW-1:0];
        ram_we = 1'b1;
      end
      S_INSW: begin
        ram_addr = lo_r[AddrW-1:0];
        ram_we = 1'b1;
        ram_wdata = '{mac: mac_r, id: sid_r, fresh: 1'b1};
      end
      S_CLRW: begin
        ram_addr = rd_r[AddrW-1:0];
        ram_we = 1'b1;
        ram_wdata.fresh = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      out_valid <= 1'b0;
      flood_r <= 8'd255;
      idmin_r <= 8'd1;
      idmax_r <= 8'd254;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CfgFlood: flood_r <= cfg_data;
          CfgIdMin: idmin_r <= cfg_data;
          CfgIdMax: idmax_r <= cfg_data;
          default: ;
        endcase
      end
      // In S_DONE the output register is reloaded instead of emptied.
      if (out_valid && out_ready && state_r != S_DONE) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          mode_r <= in_mode;
          mac_r <= in_mac;
          sid_r <= in_station_id;
          lo_r <= '0;
          hi_r <= count_r;
          status_r <= 1'b0;
          dest_r <= '0;
          after_age_r <= 1'b0;
          ins_pending_r <= 1'b0;
          state_r <= S_SRCH;
        end
        S_SRCH: begin
          if (lo_r == hi_r) begin
            rd_r <= lo_r;
            state_r <= S_SRCHW;
          end else begin
            state_r <= S_SRCHW;
            rd_r <= mid;
          end
        end
        S_SRCHW: begin
          if (lo_r == hi_r) begin
            state_r <= S_DECIDE;
          end else begin
            // Read data of the probe at rd_r arrives now.
            if (ram_rdata.mac < mac_r) lo_r <= rd_r + 1'b1;
            else hi_r <= rd_r;
            state_r <= S_SRCH;
          end
        end
        S_DECIDE: begin
          // Entry at lo_r is in ram_rdata (read when lo_r == hi_r).
          if (!after_age_r) hit_r <= (lo_r < count_r) && (ram_rdata.mac == mac_r);
          priority case (mode_r)
            ModeLookup: begin
              dest_r <= ((lo_r < count_r) && (ram_rdata.mac == mac_r))
                        ? ram_rdata.id : flood_r;
              state_r <= S_DONE;
            end
            ModeLearn: begin
              if (!id_ok) begin
                status_r <= 1'b1;
                state_r <= S_DONE;
              end else if ((lo_r < count_r) && (ram_rdata.mac == mac_r)) begin
                wr_r <= lo_r;
                state_r <= S_INSW;
              end else if (count_r >= CntW'(TableDepth)) begin
                if (!after_age_r) begin
                  ins_pending_r <= 1'b1;
                  walk_r <= W_STALE;
                  rd_r <= '0;
                  wr_r <= '0;
                  state_r <= S_WALKRD;
                end else begin
                  state_r <= S_DONE;
                end
              end else begin
                ins_pending_r <= 1'b1;
                wr_r <= count_r;
                state_r <= (count_r > lo_r) ? S_SHIFTRD : S_INSW;
                rd_r <= count_r - 1'b1;
              end
            end
            ModeDelMac: begin
              if ((lo_r < count_r) && (ram_rdata.mac == mac_r)) begin
                walk_r <= W_DEL;
                rd_r <= lo_r + 1'b1;
                wr_r <= lo_r;
                state_r <= (lo_r + 1'b1 < count_r) ? S_WALKRD : S_AGEEND;
              end else begin
                state_r <= S_DONE;
              end
            end
            ModeDelId: begin
              if (!id_ok) begin
                status_r <= 1'b1;
                state_r <= S_DONE;
              end else begin
                walk_r <= W_ID;
                rd_r <= '0;
                wr_r <= '0;
                state_r <= (count_r != 0) ? S_WALKRD : S_DONE;
              end
            end
            ModeTick: begin
              rd_r <= '0;
              if (count_r >= CntW'(TableDepth)) begin
                walk_r <= W_STALE;
                wr_r <= '0;
                state_r <= S_WALKRD;
              end else begin
                state_r <= (count_r != 0) ? S_CLRRD : S_DONE;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_WALKRD: state_r <= S_WALKW;
        S_WALKW: begin
          if (ram_we) wr_r <= wr_r + 1'b1;
          rd_r <= rd_r + 1'b1;
          state_r <= (rd_r + 1'b1 < count_r) ? S_WALKRD : S_AGEEND;
        end
        S_AGEEND: begin
          unique case (walk_r)
            W_DEL: begin
              count_r <= count_r - 1'b1;
              state_r <= S_DONE;
            end
            W_ID: begin
              count_r <= wr_r;
              state_r <= S_DONE;
            end
            default: begin
              if (wr_r >= CntW'(TableDepth) && KeepAfterTrim < TableDepth)
                count_r <= CntW'(KeepAfterTrim);
              else count_r <= wr_r;
              rd_r <= '0;
              state_r <= (wr_r != 0) ? S_CLRRD : (ins_pending_r ? S_SRCH : S_DONE);
              if (wr_r == 0 && ins_pending_r) begin
                after_age_r <= 1'b1;
                lo_r <= '0;
                hi_r <= '0;
              end
            end
          endcase
        end
        S_CLRRD: state_r <= S_CLRW;
        S_CLRW: begin
          rd_r <= rd_r + 1'b1;
          if (rd_r + 1'b1 < count_r) state_r <= S_CLRRD;
          else if (ins_pending_r) begin
            // Search again for the insert position in the aged table.
            after_age_r <= 1'b1;
            lo_r <= '0;
            hi_r <= count_r;
            state_r <= S_SRCH;
          end else state_r <= S_DONE;
        end
        S_SHIFTRD: state_r <= S_SHIFTW;
        S_SHIFTW: begin
          wr_r <= wr_r - 1'b1;
          rd_r <= rd_r - 1'b1;
          state_r <= (wr_r - 1'b1 > lo_r) ? S_SHIFTRD : S_INSW;
        end
        S_INSW: begin
          if (ins_pending_r) count_r <= count_r + 1'b1;
          state_r <= S_DONE;
        end
        S_DONE: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          out_hit <= hit_r;
          out_dest_id <= dest_r;
          out_entry_count <= count_r;
          out_status <= status_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(TableDepth)) else $error("count above depth");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready during work");
  a_wr_le_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALKW) |-> (wr_r <= rd_r)) else $error("compaction overrun");
`endif
endmodule
`default_nettype wire
